// ----- design/iiss_pkg.sv -----
// Package for the indexed insert sequence store.
// Holds the word types, status and cell operation codes; no dependencies.
`default_nettype none

package iiss_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned POS_W  = 6;
    localparam int unsigned FILL_W = 6;

    localparam logic [1:0] ST_LIST    = 2'd0;
    localparam logic [1:0] ST_BAD_POS = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_ROT_L  = 2'd2;
    localparam logic [1:0] OP_ROT_R  = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] item_value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] element;
        logic                     backward;
        logic                     last_result;
    } res_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic [1:0]               op;
        logic [POS_W-1:0]         pos;
        logic [FILL_W-1:0]        fill;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] head;
        logic signed [DATA_W-1:0] tail;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- design/iiss_cell.sv -----
// One slot of the sequence chain: holds a single word and takes its
// neighbour's word on insert or rotate. Depends on iiss_pkg.
`default_nettype none

module iiss_cell
    import iiss_pkg::*;
#(
    parameter int unsigned INDEX = 0
)
(
    input  wire logic                     clk,
    input  wire cell_ctrl_t               ctrl,
    input  wire logic signed [DATA_W-1:0] left,
    input  wire logic signed [DATA_W-1:0] right,
    output logic signed [DATA_W-1:0]      value,
    output logic signed [DATA_W-1:0]      tap
);

    localparam logic [FILL_W-1:0] IDX     = FILL_W'(INDEX);
    localparam logic [FILL_W-1:0] IDX_P1  = FILL_W'(INDEX + 1);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        case (ctrl.op)
            OP_INSERT:
            begin
                if (IDX == ctrl.pos)
                begin
                    value_next = ctrl.value;
                end
                else if ((IDX > ctrl.pos) && (IDX <= ctrl.fill))
                begin
                    value_next = left;
                end
            end
            OP_ROT_L:
            begin
                // tail of the occupied window wraps round to the head
                if (IDX_P1 == ctrl.fill)
                begin
                    value_next = ctrl.head;
                end
                else if (IDX_P1 < ctrl.fill)
                begin
                    value_next = right;
                end
            end
            OP_ROT_R:
            begin
                if (IDX == '0)
                begin
                    value_next = ctrl.tail;
                end
                else if (IDX < ctrl.fill)
                begin
                    value_next = left;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign tap   = (IDX_P1 == ctrl.fill) ? value_reg : '0;

endmodule

`default_nettype wire

// ----- design/indexed_insert_sequence_store_core.sv -----
// A rejected word gives its single status result in the cycle after acceptance.
// An insert takes effect on the accept edge; its 2*n listing results follow on
// consecutive cycles, n = new count, paced by one rotation of the cell chain per result.
// A word is accepted only when not busy; busy lasts for the listing, not for a reject.
// Reset empties the sequence at once; slot contents are left as they are.
// Results cannot be stalled: each is valid on result while strobe is high.
`default_nettype none

module indexed_insert_sequence_store_core
    import iiss_pkg::*;
#(
    parameter int unsigned CAPACITY = 32
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire req_t request,
    output res_t      result,
    output logic      strobe
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_FWD  = 2'd1;
    localparam logic [1:0] S_BWD  = 2'd2;

    localparam logic [FILL_W-1:0] CAP = FILL_W'(CAPACITY);

    logic [1:0]        state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              strobe_reg, strobe_next;
    res_t              result_reg, result_next;

    cell_ctrl_t               ctrl;
    logic signed [DATA_W-1:0] values [CAPACITY];
    logic signed [DATA_W-1:0] taps   [CAPACITY];
    logic signed [DATA_W-1:0] tail;
    logic                     accept;
    logic                     pos_ok;
    logic                     full;
    logic                     at_end;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [DATA_W-1:0] left_w;
            logic signed [DATA_W-1:0] right_w;
            if (g == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_mid
                assign left_w = values[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_inner
                assign right_w = values[g+1];
            end
            iiss_cell #(.INDEX(g)) u_cell (
                .clk   (clk),
                .ctrl  (ctrl),
                .left  (left_w),
                .right (right_w),
                .value (values[g]),
                .tap   (taps[g])
            );
        end
    endgenerate

    always_comb
    begin
        tail = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            tail = tail | taps[i];
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign pos_ok = (request.position <= fill_reg);
    assign full   = (fill_reg >= CAP);
    assign at_end = ({1'b0, cnt_reg} == (fill_reg - FILL_W'(1)));

    always_comb
    begin
        ctrl.op    = OP_HOLD;
        ctrl.pos   = request.position;
        ctrl.fill  = fill_reg;
        ctrl.value = request.item_value;
        ctrl.head  = values[0];
        ctrl.tail  = tail;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && pos_ok && !full)
                begin
                    ctrl.op = OP_INSERT;
                end
            end
            S_FWD:   ctrl.op = OP_ROT_L;
            S_BWD:   ctrl.op = OP_ROT_R;
            default: ctrl.op = OP_HOLD;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        cnt_next    = cnt_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!pos_ok || full)
                    begin
                        strobe_next             = 1'b1;
                        result_next.status      = pos_ok ? ST_FULL : ST_BAD_POS;
                        result_next.element     = '0;
                        result_next.backward    = 1'b0;
                        result_next.last_result = 1'b1;
                    end
                    else
                    begin
                        fill_next  = fill_reg + FILL_W'(1);
                        cnt_next   = '0;
                        state_next = S_FWD;
                    end
                end
            end
            S_FWD:
            begin
                strobe_next             = 1'b1;
                result_next.status      = ST_LIST;
                result_next.element     = values[0];
                result_next.backward    = 1'b0;
                result_next.last_result = 1'b0;
                cnt_next                = cnt_reg + 5'd1;
                if (at_end)
                begin
                    cnt_next   = '0;
                    state_next = S_BWD;
                end
            end
            S_BWD:
            begin
                strobe_next             = 1'b1;
                result_next.status      = ST_LIST;
                result_next.element     = tail;
                result_next.backward    = 1'b1;
                result_next.last_result = at_end;
                cnt_next                = cnt_reg + 5'd1;
                if (at_end)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign strobe = strobe_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CAP)
        else $error("fill count beyond capacity");

    a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (fill_reg != '0))
        else $error("listing with an empty sequence");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (result.status != ST_LIST)) |-> result.last_result)
        else $error("status result not marked last");

    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BWD && at_end) |=> !busy && strobe && result.last_result)
        else $error("backward pass did not close the listing");

endmodule

`default_nettype wire
